>>> sv/sorted_record_table_assert.svh
// Assertion macros for the sorted record table.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef SORTED_RECORD_TABLE_ASSERT_SVH
`define SORTED_RECORD_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop on every rising edge of clk, disabled while rst_n is low.
`define SRT_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sorted_record_table: assertion failed");
// Same, on the block's own clock and reset.
`define SRT_ASSERT(label, prop) `SRT_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define SRT_ASSERT_CLK(label, clk, rst_n, prop)
`define SRT_ASSERT(label, prop)
`endif

`endif

>>> sv/srt_pkg.sv
// Shared types and constants for the sorted record table.
// No dependencies; imported by srt_seq, sorted_record_table and the bench files.
`default_nettype none

package srt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned FLD_W = 2;
  localparam int unsigned POS_W = 7;
  localparam int unsigned REC_W = KEY_W + 2 * FLD_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_MODIFY = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_ACT,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [FLD_W-1:0]   found_type;
    logic [FLD_W-1:0]   found_availability;
    logic [POS_W-1:0]   count_after;
  } result_t;

endpackage

`default_nettype wire

>>> sv/srt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srt_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/srt_seq.sv
// Request sequencer: binary search and entry shifting over the record RAM.
// Depends on srt_pkg and srt_ram.
`default_nettype none

module srt_seq #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [srt_pkg::KEY_W-1:0]     key_i,
  input  wire logic [srt_pkg::FLD_W-1:0]     room_type_i,
  input  wire logic [srt_pkg::FLD_W-1:0]     availability_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output srt_pkg::result_t                   res_o
);

  import srt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  req_e             req_q, req_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [FLD_W-1:0] ty_q, ty_d;
  logic [FLD_W-1:0] av_q, av_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi_q, hi_d;
  logic [CW-1:0]    mid_q, mid_d;
  logic             hit_q, hit_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [FLD_W-1:0] ft_q, ft_d;
  logic [FLD_W-1:0] fa_q, fa_d;
  status_e          status_q, status_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    i_q, i_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    dst_q, dst_d;

  logic [CW-1:0]    mid;
  logic [CW-1:0]    i_dec;
  logic [CW-1:0]    i_inc;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [FLD_W-1:0] rd_ty;
  logic [FLD_W-1:0] rd_av;

  srt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata[REC_W-1 -: KEY_W];
  assign rd_ty  = ram_rdata[2*FLD_W-1 -: FLD_W];
  assign rd_av  = ram_rdata[FLD_W-1:0];
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign i_dec  = i_q - CW'(1);
  assign i_inc  = i_q + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    key_q    <= key_d;
    ty_q     <= ty_d;
    av_q     <= av_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    hit_q    <= hit_d;
    pos_q    <= pos_d;
    ft_q     <= ft_d;
    fa_q     <= fa_d;
    status_q <= status_d;
    i_q      <= i_d;
    dst_q    <= dst_d;
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    key_d     = key_q;
    ty_d      = ty_q;
    av_d      = av_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    hit_d     = hit_q;
    pos_d     = pos_q;
    ft_d      = ft_q;
    fa_d      = fa_q;
    status_d  = status_q;
    count_d   = count_q;
    i_d       = i_q;
    pend_d    = pend_q;
    dst_d     = dst_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = req_e'(req_type_i);
          key_d   = key_i;
          ty_d    = room_type_i;
          av_d    = availability_i;
          lo_d    = '0;
          hi_d    = count_q;
          hit_d   = 1'b0;
          ft_d    = '0;
          fa_d    = '0;
          state_d = ST_SRCH;
        end
      end

      ST_SRCH: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid[AW-1:0];
          mid_d     = mid;
          state_d   = ST_CMP;
        end else begin
          pos_d   = lo_q;
          state_d = ST_ACT;
        end
      end

      ST_CMP: begin
        if (rd_key == key_q) begin
          hit_d   = 1'b1;
          pos_d   = mid_q;
          ft_d    = rd_ty;
          fa_d    = rd_av;
          state_d = ST_ACT;
        end else if (key_q < rd_key) begin
          hi_d    = mid_q;
          state_d = ST_SRCH;
        end else begin
          lo_d    = mid_q + CW'(1);
          state_d = ST_SRCH;
        end
      end

      ST_ACT: begin
        state_d = ST_DONE;
        if (req_q == REQ_INSERT) begin
          if (hit_q) begin
            status_d = STATUS_DUPLICATE;
          end else if (count_q >= CW'(CAPACITY)) begin
            status_d = STATUS_FULL;
          end else begin
            status_d = STATUS_OK;
            i_d      = count_q;
            pend_d   = 1'b0;
            state_d  = ST_SHIFT;
          end
        end else if (!hit_q) begin
          status_d = STATUS_NOT_FOUND;
        end else begin
          status_d = STATUS_OK;
          case (req_q)
            REQ_DELETE: begin
              i_d     = pos_q + CW'(1);
              pend_d  = 1'b0;
              state_d = ST_SHIFT;
            end
            REQ_MODIFY: begin
              ram_we    = 1'b1;
              ram_waddr = pos_q[AW-1:0];
              ram_wdata = {key_q, ty_q, av_q};
            end
            default: begin
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // read one entry per cycle, write it back one place over next cycle
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end
        if (req_q == REQ_INSERT) begin
          if (i_q > pos_q) begin
            ram_raddr = i_dec[AW-1:0];
            dst_d     = i_q[AW-1:0];
            i_d       = i_dec;
            pend_d    = 1'b1;
          end else begin
            pend_d = 1'b0;
            if (!pend_q) begin
              ram_we    = 1'b1;
              ram_waddr = pos_q[AW-1:0];
              ram_wdata = {key_q, ty_q, av_q};
              count_d   = count_q + CW'(1);
              state_d   = ST_DONE;
            end
          end
        end else begin
          if (i_q < count_q) begin
            ram_raddr = i_q[AW-1:0];
            dst_d     = i_dec[AW-1:0];
            i_d       = i_inc;
            pend_d    = 1'b1;
          end else begin
            pend_d = 1'b0;
            if (!pend_q) begin
              count_d = count_q - CW'(1);
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.status             = status_q;
  assign res_o.position           = POS_W'(pos_q);
  assign res_o.found_type         = ft_q;
  assign res_o.found_availability = fa_q;
  assign res_o.count_after        = POS_W'(count_q);

endmodule

`default_nettype wire

>>> sv/sorted_record_table.sv
// Sorted record table: up to CAPACITY records held in ascending key order in one
// RAM. A request binary-searches the table; each probe is a RAM read, then a
// compare, and when the key is absent the search ends with a closing bound check.
// An insert then moves every later entry one place right and a delete every later
// entry one place left, one entry per cycle through the single RAM port pair.
// Each request passes accept, search, action, a shift for an insert or delete, and
// result handoff; its result may then wait for the output register.
// One request is worked at a time; the next one is taken while the previous
// result waits in the output register.
// Depends on srt_pkg, srt_seq, srt_ram and sorted_record_table_assert.svh.
`default_nettype none

`include "sorted_record_table_assert.svh"

module sorted_record_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                req_type_i,
  input  wire logic [srt_pkg::KEY_W-1:0] key_i,
  input  wire logic [srt_pkg::FLD_W-1:0] room_type_i,
  input  wire logic [srt_pkg::FLD_W-1:0] availability_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     status_o,
  output logic [srt_pkg::POS_W-1:0]      position_o,
  output logic [srt_pkg::FLD_W-1:0]      found_type_o,
  output logic [srt_pkg::FLD_W-1:0]      found_availability_o,
  output logic [srt_pkg::POS_W-1:0]      count_after_o
);

  import srt_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_q;
  logic    out_valid_q;

  srt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .key_i          (key_i),
    .room_type_i    (room_type_i),
    .availability_i (availability_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_q.status;
  assign position_o           = out_q.position;
  assign found_type_o         = out_q.found_type;
  assign found_availability_o = out_q.found_availability;
  assign count_after_o        = out_q.count_after;

  // one request in flight: after a transaction on the input, not ready at once
  `SRT_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)
  // a refused insert for lack of room reports a full table
  `SRT_ASSERT(a_full_count, out_valid_o && status_o == STATUS_FULL |->
    count_after_o == POS_W'(CAPACITY))
  // no record matched: nothing reported from the table
  `SRT_ASSERT(a_miss_no_fields,
    out_valid_o && (status_o == STATUS_NOT_FOUND || status_o == STATUS_FULL) |->
    found_type_o == '0 && found_availability_o == '0)

endmodule

`default_nettype wire

>>> bench/record_table_checker.sv
// Scoreboard for sorted_record_table: mirrors the table contents, predicts one
// answer per accepted request and compares it with the answer the block returns.
// Depends on srt_pkg.
module record_table_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                req_type_i,
  input  logic [srt_pkg::KEY_W-1:0] key_i,
  input  logic [srt_pkg::FLD_W-1:0] room_type_i,
  input  logic [srt_pkg::FLD_W-1:0] availability_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [1:0]                status_i,
  input  logic [srt_pkg::POS_W-1:0] position_i,
  input  logic [srt_pkg::FLD_W-1:0] found_type_i,
  input  logic [srt_pkg::FLD_W-1:0] found_availability_i,
  input  logic [srt_pkg::POS_W-1:0] count_after_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  logic [KEY_W-1:0] table_keys   [CAPACITY];
  logic [FLD_W-1:0] table_types  [CAPACITY];
  logic [FLD_W-1:0] table_avails [CAPACITY];
  int unsigned      record_total;
  result_t          expected_answers [$];

  initial begin
    record_total     = 0;
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  // Binary search, then apply the request to the mirrored table.
  task automatic predict_answer(input req_e req, input logic [KEY_W-1:0] k,
                                input logic [FLD_W-1:0] ty,
                                input logic [FLD_W-1:0] av,
                                output result_t answer);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned idx;
    bit          hit;
    lo     = 0;
    hi     = record_total;
    hit    = 1'b0;
    answer = '0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (table_keys[mid] == k) begin
        hit = 1'b1;
        lo  = mid;
      end else if (k < table_keys[mid]) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    answer.position = POS_W'(lo);
    if (hit) begin
      answer.found_type         = table_types[lo];
      answer.found_availability = table_avails[lo];
    end
    if (req == REQ_INSERT) begin
      if (hit) begin
        answer.status = STATUS_DUPLICATE;
      end else if (record_total >= CAPACITY) begin
        answer.status = STATUS_FULL;
      end else begin
        for (idx = record_total; idx > lo; idx--) begin
          table_keys[idx]   = table_keys[idx-1];
          table_types[idx]  = table_types[idx-1];
          table_avails[idx] = table_avails[idx-1];
        end
        table_keys[lo]   = k;
        table_types[lo]  = ty;
        table_avails[lo] = av;
        record_total++;
        answer.status = STATUS_OK;
      end
    end else if (!hit) begin
      answer.status = STATUS_NOT_FOUND;
    end else begin
      answer.status = STATUS_OK;
      if (req == REQ_DELETE) begin
        for (idx = lo; idx + 1 < record_total; idx++) begin
          table_keys[idx]   = table_keys[idx+1];
          table_types[idx]  = table_types[idx+1];
          table_avails[idx] = table_avails[idx+1];
        end
        record_total--;
      end else if (req == REQ_MODIFY) begin
        table_types[lo]  = ty;
        table_avails[lo] = av;
      end
    end
    answer.count_after = POS_W'(record_total);
  endtask

  task automatic compare_field(input string name, input logic [31:0] expd,
                               input logic [31:0] got);
    if (got !== expd) begin
      $error("%s mismatch: expected %0d, got %0d", name, expd, got);
      mismatch_count_o++;
    end
  endtask

  // Answers are retired before requests: one accepted in this cycle cannot
  // have produced an answer yet.
  always @(posedge clk_i) begin : monitor
    result_t predicted;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          $error("answer with no request pending: status %0d position %0d",
                 status_i, position_i);
          mismatch_count_o++;
        end else begin
          predicted = expected_answers.pop_front();
          compare_field("status", predicted.status, status_i);
          compare_field("position", predicted.position, position_i);
          compare_field("found_type", predicted.found_type, found_type_i);
          compare_field("found_availability", predicted.found_availability,
                        found_availability_i);
          compare_field("count_after", predicted.count_after, count_after_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_answer(req_e'(req_type_i), key_i, room_type_i, availability_i,
                       predicted);
        expected_answers.push_back(predicted);
      end
      outstanding_o = expected_answers.size();
    end
  end

endmodule

>>> bench/testbench.sv
// Top of the sorted_record_table bench: clock, reset, request stimulus and
// answer back-pressure; checking is done by record_table_checker.
// Depends on srt_pkg, record_table_checker and the sorted_record_table RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned KEY_POOL     = 96;
  localparam int unsigned BLOCKS       = 8;
  localparam int unsigned BLOCK_LEN    = 250;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic             clk;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  req_e             req_type       = REQ_LOOKUP;
  logic [KEY_W-1:0] key            = '0;
  logic [FLD_W-1:0] room_type      = '0;
  logic [FLD_W-1:0] availability   = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [1:0]       status;
  logic [POS_W-1:0] position;
  logic [FLD_W-1:0] found_type;
  logic [FLD_W-1:0] found_availability;
  logic [POS_W-1:0] count_after;
  int unsigned      mismatches;
  int unsigned      outstanding;

  // Keys are mostly drawn from a pool a bit larger than the table, so that
  // inserts fill it up and duplicates and misses both occur often.
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  bit               in_no_gaps   = 1'b0;
  bit               out_no_stall = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  sorted_record_table #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .req_type_i           (req_type),
    .key_i                (key),
    .room_type_i          (room_type),
    .availability_i       (availability),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .status_o             (status),
    .position_o           (position),
    .found_type_o         (found_type),
    .found_availability_o (found_availability),
    .count_after_o        (count_after)
  );

  record_table_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .req_type_i           (req_type),
    .key_i                (key),
    .room_type_i          (room_type),
    .availability_i       (availability),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .status_i             (status),
    .position_i           (position),
    .found_type_i         (found_type),
    .found_availability_i (found_availability),
    .count_after_i        (count_after),
    .mismatch_count_o     (mismatches),
    .outstanding_o        (outstanding)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input req_e req, input logic [KEY_W-1:0] k,
                              input logic [FLD_W-1:0] ty,
                              input logic [FLD_W-1:0] av);
    int unsigned gap;
    gap = in_no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    key          <= k;
    room_type    <= ty;
    availability <= av;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Fresh keys are only used where they cannot end up stored.
  function automatic logic [KEY_W-1:0] pick_key(input bit allow_fresh);
    if (allow_fresh && $urandom_range(0, 99) < 15) begin
      return $urandom;
    end
    return key_pool[$urandom_range(0, KEY_POOL-1)];
  endfunction

  function automatic req_e pick_request(input bit fill);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (fill) begin
      if (roll < 75) return REQ_INSERT;
      if (roll < 80) return REQ_DELETE;
      if (roll < 90) return REQ_MODIFY;
      return REQ_LOOKUP;
    end
    if (roll < 10) return REQ_INSERT;
    if (roll < 70) return REQ_DELETE;
    if (roll < 85) return REQ_MODIFY;
    return REQ_LOOKUP;
  endfunction

  initial begin : answer_sink
    int unsigned stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = out_no_stall ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned blk;
    int unsigned n;
    req_e        req;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (n = 2; n < KEY_POOL; n++) key_pool[n] = $urandom;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: every request misses.
    send_request(REQ_LOOKUP, 32'h0000_0000, 2'd0, 2'd0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF, 2'd1, 2'd1);
    send_request(REQ_MODIFY, 32'h8000_0000, 2'd2, 2'd2);
    // Key extremes and the unsigned midpoint.
    send_request(REQ_INSERT, 32'h0000_0000, 2'd0, 2'd0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 2'd3, 2'd3);
    send_request(REQ_INSERT, 32'h8000_0000, 2'd1, 2'd2);
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 2'd2, 2'd1);
    // Duplicate inserts are refused and report the stored record.
    send_request(REQ_INSERT, 32'h0000_0000, 2'd3, 2'd3);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 2'd0, 2'd0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 2'd0, 2'd0);
    send_request(REQ_LOOKUP, 32'h0000_0000, 2'd3, 2'd3);
    send_request(REQ_LOOKUP, 32'h1234_5678, 2'd0, 2'd0);
    // Modify reports the old values, lookup then sees the new ones.
    send_request(REQ_MODIFY, 32'h8000_0000, 2'd3, 2'd0);
    send_request(REQ_LOOKUP, 32'h8000_0000, 2'd0, 2'd0);
    send_request(REQ_MODIFY, 32'h8000_0001, 2'd1, 2'd1);
    send_request(REQ_DELETE, 32'h7FFF_FFFE, 2'd0, 2'd0);
    // Delete at the front and at the back, then an ASCII key.
    send_request(REQ_DELETE, 32'h0000_0000, 2'd0, 2'd0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF, 2'd0, 2'd0);
    send_request(REQ_INSERT, 32'h524F_4F4D, 2'd1, 2'd3);
    send_request(REQ_DELETE, 32'h8000_0000, 2'd0, 2'd0);
    send_request(REQ_DELETE, 32'h7FFF_FFFF, 2'd0, 2'd0);
    send_request(REQ_DELETE, 32'h524F_4F4D, 2'd0, 2'd0);
    send_request(REQ_LOOKUP, 32'h524F_4F4D, 2'd0, 2'd0);

    // Alternate fill-heavy and drain-heavy blocks; fills reach a full table.
    for (blk = 0; blk < BLOCKS; blk++) begin
      in_no_gaps   = ($urandom_range(0, 3) == 0);
      out_no_stall = ($urandom_range(0, 3) == 0);
      for (n = 0; n < BLOCK_LEN; n++) begin
        req = pick_request(blk % 2 == 0);
        send_request(req, pick_key(req != REQ_INSERT), FLD_W'($urandom_range(0, 3)),
                     FLD_W'($urandom_range(0, 3)));
      end
    end
    in_no_gaps   = 1'b0;
    out_no_stall = 1'b0;
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/srt_pkg.sv
sv/srt_ram.sv
sv/srt_seq.sv
sv/sorted_record_table.sv
bench/record_table_checker.sv
bench/testbench.sv
